// ----- hw/rtl/fwrx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrx_pkg
// Shared types, codes and the bytewise CRC-32 step of the firmware image
// receiver.
// ----------------------------------------------------------------------------
package fwrx_pkg;

    // command codes
    localparam logic [2:0] CMD_DATA   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_END    = 3'd2;
    localparam logic [2:0] CMD_PAUSE  = 3'd3;
    localparam logic [2:0] CMD_RESUME = 3'd4;
    localparam logic [2:0] CMD_REBOOT = 3'd5;
    localparam logic [2:0] CMD_LINK   = 3'd6;

    // result kinds
    localparam logic [2:0] KIND_ACK        = 3'd0;
    localparam logic [2:0] KIND_START_FAIL = 3'd1;
    localparam logic [2:0] KIND_CRC_OK     = 3'd2;
    localparam logic [2:0] KIND_CRC_FAIL   = 3'd3;
    localparam logic [2:0] KIND_REBOOT     = 3'd4;

    // start failure causes
    localparam logic [1:0] ERR_BEGIN      = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_WRITE      = 2'd2;

    // configuration register map
    localparam int unsigned   CFG_ADDR_W        = 3;
    localparam logic          REG_CAPACITY      = 1'b0;
    localparam logic [31:0]   CAPACITY_RESET    = 32'd1572864;

    // crc-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // ack interval, a power of two, so the threshold is a mask
    localparam logic [31:0] ACK_INTERVAL = 32'd4096;
    localparam logic [31:0] ACK_MASK     = ACK_INTERVAL - 32'd1;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  data_byte;
        logic        last_in_chunk;
        logic        has_argument;
        logic [31:0] argument;
        logic        storage_fault;
    } fwrx_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [1:0]  error_code;
        logic [31:0] acked_bytes;
    } fwrx_result_t;

    // one byte folded into the crc, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/fwrx_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrx_in_if / fwrx_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface fwrx_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  data_byte;
    logic        last_in_chunk;
    logic        has_argument;
    logic [31:0] argument;
    logic        storage_fault;

    modport source (output valid, command, data_byte, last_in_chunk, has_argument,
                    argument, storage_fault, input ready);
    modport sink   (input valid, command, data_byte, last_in_chunk, has_argument,
                    argument, storage_fault, output ready);
endinterface

interface fwrx_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [1:0]  error_code;
    logic [31:0] acked_bytes;

    modport source (output valid, result_kind, error_code, acked_bytes, input ready);
    modport sink   (input valid, result_kind, error_code, acked_bytes, output ready);
endinterface

// ----- hw/rtl/firmware_image_receive_session_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_image_receive_session_unit
// Firmware image receive session: start/data/end commands, byte counting,
// reflected CRC-32 check and interval acks.
//
//   channel   direction  handshake      contents
//   in_ch     in         valid/ready    command, data byte, chunk end, argument
//   out_ch    out        valid/ready    result kind, error code, acked bytes
//   apb       in         psel/penable   partition capacity register at 0x0
//
// One item per cycle sustained while no result stalls on out_ch.ready; an item
// passes the input register, then the result register, before its result is
// valid on out_ch.
// The crc byte step and the counter add sit between those two registers.
// A result held by out_ch.ready low stops the input register; in_ch.ready
// drops only while the input register is full and cannot move on.
// Reset clears all session state; capacity returns to 1572864 bytes.
// ----------------------------------------------------------------------------
module firmware_image_receive_session_unit
    import fwrx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fwrx_in_if.sink               in_ch,
    fwrx_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic        advance;
    logic        item_valid;
    fwrx_item_t  item;
    logic [31:0] capacity;

    // configuration registers
    fwrx_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // input register
    fwrx_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // session logic and result register
    fwrx_session_core u_session_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .capacity   (capacity),
        .advance    (advance),
        .out_ch     (out_ch)
    );

endmodule

// ----- hw/rtl/fwrx_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrx_cfg_regs
// APB register file holding the partition capacity.
// ----------------------------------------------------------------------------
module fwrx_cfg_regs
    import fwrx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [31:0]           capacity
);

    logic [31:0] capacity_reg;
    logic        wr_en;
    logic        sel_capacity;

    assign pready       = 1'b1;
    assign sel_capacity = (paddr[2] == REG_CAPACITY);
    assign wr_en        = psel && penable && pwrite;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (wr_en && sel_capacity)
        begin
            capacity_reg <= pwdata;
        end
    end

    // read mux
    always_comb
    begin
        prdata = sel_capacity ? capacity_reg : 32'd0;
    end

    assign capacity = capacity_reg;

endmodule

// ----- hw/rtl/fwrx_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrx_in_stage
// Input register for command items; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module fwrx_in_stage
    import fwrx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    fwrx_in_if.sink      in_ch,
    input  logic         advance,
    output logic         item_valid,
    output fwrx_item_t   item
);

    logic       valid_reg;
    logic       valid_next;
    fwrx_item_t item_reg;
    logic       load;

    assign in_ch.ready = !valid_reg || advance;
    assign load        = in_ch.valid && in_ch.ready;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.command       <= in_ch.command;
            item_reg.data_byte     <= in_ch.data_byte;
            item_reg.last_in_chunk <= in_ch.last_in_chunk;
            item_reg.has_argument  <= in_ch.has_argument;
            item_reg.argument      <= in_ch.argument;
            item_reg.storage_fault <= in_ch.storage_fault;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hw/rtl/fwrx_session_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrx_session_core
// Session state, byte counter, crc and ack threshold; decides each item and
// registers the result.
// ----------------------------------------------------------------------------
module fwrx_session_core
    import fwrx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  fwrx_item_t   item,
    input  logic [31:0]  capacity,
    output logic         advance,
    fwrx_out_if.source   out_ch
);

    logic         active_reg,  active_next;
    logic         paused_reg,  paused_next;
    logic         ended_reg,   ended_next;
    logic         storage_reg, storage_next;
    logic [31:0]  total_reg,   total_next;
    logic [31:0]  count_reg,   count_next;
    logic [31:0]  crc_reg,     crc_next;
    logic [31:0]  ack_thr_reg, ack_thr_next;
    logic         out_valid_reg, out_valid_next;
    fwrx_result_t result_reg;

    logic         emit;
    fwrx_result_t result;
    logic [31:0]  count_inc;
    logic [31:0]  thr;

    // an item is taken whenever the result slot is free or being drained
    assign advance   = item_valid && (!out_valid_reg || out_ch.ready);
    assign count_inc = count_reg + 32'd1;
    assign thr       = count_inc & ~ACK_MASK;

    // command decode and state update
    always_comb
    begin
        active_next  = active_reg;
        paused_next  = paused_reg;
        ended_next   = ended_reg;
        storage_next = storage_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        ack_thr_next = ack_thr_reg;
        emit         = 1'b0;
        result       = '0;
        unique case (item.command)
            CMD_DATA:
            begin
                if (active_reg && !paused_reg && !ended_reg)
                begin
                    if (!storage_reg)
                    begin
                        active_next        = 1'b0;
                        emit               = 1'b1;
                        result.result_kind = KIND_START_FAIL;
                        result.error_code  = ERR_UNEXPECTED;
                    end
                    else if (item.storage_fault)
                    begin
                        storage_next       = 1'b0;
                        active_next        = 1'b0;
                        emit               = 1'b1;
                        result.result_kind = KIND_START_FAIL;
                        result.error_code  = ERR_WRITE;
                    end
                    else
                    begin
                        count_next = count_inc;
                        crc_next   = crc32_byte(crc_reg, item.data_byte);
                        if (item.last_in_chunk && (thr > ack_thr_reg))
                        begin
                            ack_thr_next       = thr;
                            emit               = 1'b1;
                            result.result_kind = KIND_ACK;
                            result.acked_bytes = count_inc;
                        end
                    end
                end
            end
            CMD_START:
            begin
                emit = 1'b1;
                if (!item.has_argument || (item.argument == 32'd0))
                begin
                    result.result_kind = KIND_START_FAIL;
                    result.error_code  = ERR_BEGIN;
                end
                else
                begin
                    total_next   = 32'd0;
                    count_next   = 32'd0;
                    ack_thr_next = 32'd0;
                    paused_next  = 1'b0;
                    ended_next   = 1'b0;
                    crc_next     = CRC_INIT;
                    if (item.argument > capacity)
                    begin
                        storage_next       = 1'b0;
                        result.result_kind = KIND_START_FAIL;
                        result.error_code  = ERR_BEGIN;
                    end
                    else
                    begin
                        storage_next       = 1'b1;
                        total_next         = item.argument;
                        active_next        = 1'b1;
                        result.result_kind = KIND_ACK;
                    end
                end
            end
            CMD_END:
            begin
                emit               = 1'b1;
                result.result_kind = KIND_CRC_FAIL;
                if (item.has_argument && active_reg)
                begin
                    storage_next = 1'b0;
                    if ((count_reg != total_reg) || ((crc_reg ^ CRC_INIT) != item.argument)
                        || !storage_reg)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        ended_next         = 1'b1;
                        result.result_kind = KIND_CRC_OK;
                    end
                end
            end
            CMD_PAUSE:
            begin
                paused_next = 1'b1;
            end
            CMD_RESUME:
            begin
                paused_next = 1'b0;
            end
            CMD_REBOOT:
            begin
                emit               = 1'b1;
                result.result_kind = KIND_REBOOT;
            end
            CMD_LINK:
            begin
                active_next = 1'b0;
                paused_next = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // result slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            paused_reg    <= 1'b0;
            ended_reg     <= 1'b0;
            storage_reg   <= 1'b0;
            total_reg     <= 32'd0;
            count_reg     <= 32'd0;
            crc_reg       <= 32'd0;
            ack_thr_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                active_reg  <= active_next;
                paused_reg  <= paused_next;
                ended_reg   <= ended_next;
                storage_reg <= storage_next;
                total_reg   <= total_next;
                count_reg   <= count_next;
                crc_reg     <= crc_next;
                ack_thr_reg <= ack_thr_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_kind = result_reg.result_kind;
    assign out_ch.error_code  = result_reg.error_code;
    assign out_ch.acked_bytes = result_reg.acked_bytes;

    // a finished session never keeps storage open
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ended_reg && storage_reg))
        else $error("ended session with storage still running");

    // ack threshold stays on an interval boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        (ack_thr_reg & ACK_MASK) == 32'd0)
        else $error("ack threshold off interval boundary");

    // no item is taken while a result waits unclaimed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !advance)
        else $error("item taken over a stalled result");

    // a good start answers with an ack of zero bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (item.command == CMD_START) && item.has_argument
         && (item.argument != 32'd0) && (item.argument <= capacity))
        |=> (out_valid_reg && (result_reg.result_kind == KIND_ACK)
             && (result_reg.acked_bytes == 32'd0)))
        else $error("good start without zero-count ack");

endmodule

// ----- tb/sv/firmware_image_receive_session_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_image_receive_session_unit_tb
// Self-checking bench for the firmware image receiver. A directed table walks
// the session commands and their failure paths, then random sessions with
// random chunking, pauses, noise and storage faults run under several
// partition capacities. Every accepted command goes through an in-bench
// session predictor (byte count, crc-32, ack threshold) and each result
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module firmware_image_receive_session_unit_tb;
    import fwrx_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 820;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CFG_SPACING  = 150;

    // command code with no meaning, must be ignored
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] CAPACITY_ADDR = CFG_ADDR_W'(4 * REG_CAPACITY);

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    fwrx_in_if  in_ch ();
    fwrx_out_if out_ch ();

    firmware_image_receive_session_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // session predictor state
    logic        sess_on;
    logic        sess_held;
    logic        sess_done;
    logic        store_busy;
    logic [31:0] img_size;
    logic [31:0] byte_cnt;
    logic [31:0] crc_acc;
    logic [31:0] ack_mark;
    logic [31:0] cap_limit;

    fwrx_result_t pending_results[$];

    typedef struct {
        fwrx_item_t   item;
        bit           crc_arg;
        bit           fixed;
        fwrx_result_t want;
    } session_vector_t;

    session_vector_t vectors[$];

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned stall_left;
    int unsigned flow_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // reflected crc-32, one bit at a time
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ data[k];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic predictor_reset();
        sess_on    = 1'b0;
        sess_held  = 1'b0;
        sess_done  = 1'b0;
        store_busy = 1'b0;
        img_size   = '0;
        byte_cnt   = '0;
        crc_acc    = '0;
        ack_mark   = '0;
        cap_limit  = CAPACITY_RESET;
    endtask

    // advance the session by one command, returns 1 when a result is due
    function automatic bit predict_receive(input fwrx_item_t it, output fwrx_result_t res);
        logic [31:0] mark;
        res = '0;
        case (it.command)
            CMD_DATA:
            begin
                if (!sess_on || sess_held || sess_done)
                    return 1'b0;
                if (!store_busy)
                begin
                    sess_on = 1'b0;
                    res.result_kind = KIND_START_FAIL;
                    res.error_code  = ERR_UNEXPECTED;
                    return 1'b1;
                end
                if (it.storage_fault)
                begin
                    store_busy = 1'b0;
                    sess_on    = 1'b0;
                    res.result_kind = KIND_START_FAIL;
                    res.error_code  = ERR_WRITE;
                    return 1'b1;
                end
                byte_cnt = byte_cnt + 32'd1;
                crc_acc  = crc_fold(crc_acc, it.data_byte);
                if (!it.last_in_chunk)
                    return 1'b0;
                mark = byte_cnt - (byte_cnt % ACK_INTERVAL);
                if (mark > ack_mark)
                begin
                    ack_mark = mark;
                    res.result_kind = KIND_ACK;
                    res.acked_bytes = byte_cnt;
                    return 1'b1;
                end
                return 1'b0;
            end
            CMD_START:
            begin
                res.result_kind = KIND_START_FAIL;
                res.error_code  = ERR_BEGIN;
                if (!it.has_argument || it.argument == 32'd0)
                    return 1'b1;
                img_size  = '0;
                byte_cnt  = '0;
                ack_mark  = '0;
                sess_held = 1'b0;
                sess_done = 1'b0;
                crc_acc   = CRC_INIT;
                if (it.argument > cap_limit)
                begin
                    store_busy = 1'b0;
                    return 1'b1;
                end
                store_busy = 1'b1;
                img_size   = it.argument;
                sess_on    = 1'b1;
                res.result_kind = KIND_ACK;
                res.error_code  = ERR_BEGIN;
                res.acked_bytes = byte_cnt;
                return 1'b1;
            end
            CMD_END:
            begin
                res.result_kind = KIND_CRC_FAIL;
                if (!it.has_argument || !sess_on)
                    return 1'b1;
                if (byte_cnt != img_size || ~crc_acc != it.argument || !store_busy)
                begin
                    store_busy = 1'b0;
                    sess_on    = 1'b0;
                    return 1'b1;
                end
                store_busy = 1'b0;
                sess_done  = 1'b1;
                res.result_kind = KIND_CRC_OK;
                return 1'b1;
            end
            CMD_PAUSE:
            begin
                sess_held = 1'b1;
                return 1'b0;
            end
            CMD_RESUME:
            begin
                sess_held = 1'b0;
                return 1'b0;
            end
            CMD_REBOOT:
            begin
                res.result_kind = KIND_REBOOT;
                return 1'b1;
            end
            CMD_LINK:
            begin
                sess_on   = 1'b0;
                sess_held = 1'b0;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic fwrx_item_t make_item(input logic [2:0] cmd, input logic [7:0] data,
                                             input bit last, input bit has_arg,
                                             input logic [31:0] arg, input bit fault);
        fwrx_item_t it;
        it.command       = cmd;
        it.data_byte     = data;
        it.last_in_chunk = last;
        it.has_argument  = has_arg;
        it.argument      = arg;
        it.storage_fault = fault;
        return it;
    endfunction

    function automatic fwrx_item_t random_item();
        return make_item(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
    endfunction

    // mostly the declared size, sometimes one off
    function automatic int unsigned byte_count_for(input int unsigned size);
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0)
            return size + 1;
        if (roll == 1)
            return size - 1;
        return size;
    endfunction

    task automatic add_vector(input logic [2:0] cmd, input logic [7:0] data, input bit last,
                              input bit has_arg, input logic [31:0] arg, input bit fault,
                              input bit crc_arg, input bit fixed, input logic [2:0] kind,
                              input logic [1:0] err, input logic [31:0] count);
        session_vector_t v;
        v.item                 = make_item(cmd, data, last, has_arg, arg, fault);
        v.crc_arg              = crc_arg;
        v.fixed                = fixed;
        v.want.result_kind     = kind;
        v.want.error_code      = err;
        v.want.acked_bytes     = count;
        vectors.push_back(v);
    endtask

    // one command transaction, sent in bursts with random gaps
    task automatic send_item(input fwrx_item_t it, input bit fixed, input fwrx_result_t want);
        fwrx_result_t res;
        int unsigned  gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_ch.command       = it.command;
        in_ch.data_byte     = it.data_byte;
        in_ch.last_in_chunk = it.last_in_chunk;
        in_ch.has_argument  = it.has_argument;
        in_ch.argument      = it.argument;
        in_ch.storage_fault = it.storage_fault;
        in_ch.valid         = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        if (predict_receive(it, res) && !fixed)
            pending_results.push_back(res);
        if (fixed)
            pending_results.push_back(want);
    endtask

    // let every result and every silent command drain
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write, then read back
    task automatic set_capacity(input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CAPACITY_ADDR;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cap_limit = value;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
        begin
            $display("%0t: capacity readback mismatch, expected %0h, actual %0h",
                     $time, value, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // start, chunked data with interruptions, end
    task automatic run_session(input logic [31:0] size, input int unsigned n_bytes,
                               input int unsigned chunk_limit, input int unsigned fixed_chunk,
                               input bit clean);
        int unsigned k;
        int unsigned chunk_left;
        int unsigned roll;
        fwrx_item_t  it;
        roll = clean ? 99 : $urandom_range(99);
        it = make_item(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)), roll >= 3,
                       (roll >= 3 && roll < 6) ? 32'd0 : size, 1'($urandom_range(1)));
        send_item(it, 1'b0, '0);
        chunk_left = (fixed_chunk != 0) ? fixed_chunk : $urandom_range(1, chunk_limit);
        for (k = 0; k < n_bytes; k++)
        begin
            roll = $urandom_range(999);
            if (roll < 12)
            begin
                it = random_item();
                it.command = CMD_PAUSE;
                send_item(it, 1'b0, '0);
                if (roll < 6)
                begin
                    it = random_item();
                    it.command = CMD_DATA;
                    send_item(it, 1'b0, '0);
                end
                it = random_item();
                it.command = CMD_RESUME;
                send_item(it, 1'b0, '0);
            end
            else if (roll < 18 && !clean)
                send_item(random_item(), 1'b0, '0);
            it = make_item(CMD_DATA, 8'($urandom_range(255)), chunk_left == 1 || k == n_bytes - 1,
                           1'($urandom_range(1)), $urandom,
                           !clean && $urandom_range(999) < 3);
            send_item(it, 1'b0, '0);
            chunk_left--;
            if (chunk_left == 0)
                chunk_left = (fixed_chunk != 0) ? fixed_chunk : $urandom_range(1, chunk_limit);
        end
        roll = clean ? 99 : $urandom_range(99);
        it = make_item(CMD_END, 8'($urandom_range(255)), 1'($urandom_range(1)), roll >= 5,
                       (roll < 14) ? $urandom : ~crc_acc, 1'($urandom_range(1)));
        send_item(it, 1'b0, '0);
        // data after end, dropped once the end has closed the session
        if ($urandom_range(4) == 0)
        begin
            it = random_item();
            it.command = CMD_DATA;
            send_item(it, 1'b0, '0);
        end
    endtask

    // result checking
    always @(posedge clk)
    begin : result_check
        fwrx_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual kind %0d err %0d count %0d",
                         $time, out_ch.result_kind, out_ch.error_code, out_ch.acked_bytes);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.result_kind !== want.result_kind)
                begin
                    $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                             $time, want.result_kind, out_ch.result_kind);
                    fail_count++;
                end
                if (out_ch.error_code !== want.error_code)
                begin
                    $display("%0t: error_code mismatch, expected %0d, actual %0d",
                             $time, want.error_code, out_ch.error_code);
                    fail_count++;
                end
                if (out_ch.acked_bytes !== want.acked_bytes)
                begin
                    $display("%0t: acked_bytes mismatch, expected %0d, actual %0d",
                             $time, want.acked_bytes, out_ch.acked_bytes);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ch.ready = 1'b0;
            stall_left--;
        end
        else
        begin
            out_ch.ready = 1'b1;
            if (flow_left > 0)
                flow_left--;
            else
            begin
                flow_left  = $urandom_range(0, 40);
                stall_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL firmware_image_receive_session_unit");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        fwrx_item_t  it;
        int unsigned stop_at;
        int unsigned next_cfg;
        int unsigned cfg_step;
        int unsigned roll;
        int unsigned size;
        logic [31:0] cap_value;

        fail_count   = 0;
        cycle_count  = 0;
        items_sent   = 0;
        burst_left   = 0;
        stall_left   = 0;
        flow_left    = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_DATA;
        in_ch.data_byte     = '0;
        in_ch.last_in_chunk = 1'b0;
        in_ch.has_argument  = 1'b0;
        in_ch.argument      = '0;
        in_ch.storage_fault = 1'b0;
        out_ch.ready        = 1'b0;
        predictor_reset();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: cmd, data, last, has_arg, arg, fault, crc_arg, fixed, result
        add_vector(CMD_DATA,   8'h00, 0, 0, 32'h0,        0, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_END,    8'h00, 0, 0, 32'h0,        0, 0, 1, KIND_CRC_FAIL, ERR_BEGIN, 0);
        add_vector(CMD_START,  8'h00, 0, 0, 32'hFFFFFFFF, 0, 0, 1, KIND_START_FAIL, ERR_BEGIN, 0);
        add_vector(CMD_START,  8'h00, 0, 1, 32'h0,        0, 0, 1, KIND_START_FAIL, ERR_BEGIN, 0);
        add_vector(CMD_START,  8'hFF, 1, 1, 32'hFFFFFFFF, 1, 0, 1, KIND_START_FAIL, ERR_BEGIN, 0);
        add_vector(CMD_REBOOT, 8'h00, 0, 0, 32'h0,        0, 0, 1, KIND_REBOOT, ERR_BEGIN, 0);
        add_vector(CMD_UNUSED, 8'hFF, 1, 1, 32'hFFFFFFFF, 1, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_START,  8'h00, 0, 1, 32'd3,        0, 0, 1, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_DATA,   8'h00, 0, 0, 32'h0,        0, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_PAUSE,  8'h00, 0, 0, 32'h0,        0, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_DATA,   8'hFF, 1, 0, 32'h0,        1, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_RESUME, 8'h00, 0, 0, 32'h0,        0, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_DATA,   8'hFF, 1, 0, 32'h0,        0, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_DATA,   8'hA5, 1, 0, 32'h0,        0, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_END,    8'h00, 0, 1, 32'h0,        0, 1, 1, KIND_CRC_OK, ERR_BEGIN, 0);
        add_vector(CMD_END,    8'h00, 0, 1, 32'h0,        0, 1, 1, KIND_CRC_FAIL, ERR_BEGIN, 0);
        add_vector(CMD_START,  8'h00, 0, 1, 32'd2,        0, 0, 1, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_DATA,   8'h5A, 0, 0, 32'h0,        1, 0, 1, KIND_START_FAIL, ERR_WRITE, 0);
        add_vector(CMD_START,  8'h00, 0, 1, 32'd5,        0, 0, 1, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_START,  8'h00, 0, 1, 32'hFFFFFFFF, 0, 0, 1, KIND_START_FAIL, ERR_BEGIN, 0);
        add_vector(CMD_DATA,   8'h81, 0, 0, 32'h0,        0, 0, 1, KIND_START_FAIL,
                   ERR_UNEXPECTED, 0);
        add_vector(CMD_START,  8'h00, 0, 1, 32'd4,        0, 0, 1, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_DATA,   8'h3C, 1, 0, 32'h0,        0, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_LINK,   8'h00, 0, 0, 32'h0,        0, 0, 0, KIND_ACK, ERR_BEGIN, 0);
        add_vector(CMD_END,    8'h00, 0, 1, 32'h0,        0, 1, 1, KIND_CRC_FAIL, ERR_BEGIN, 0);

        // directed part at reset capacity
        set_capacity(CAPACITY_RESET);
        foreach (vectors[i])
        begin
            it = vectors[i].item;
            if (vectors[i].crc_arg)
                it.argument = ~crc_acc;
            send_item(it, vectors[i].fixed, vectors[i].want);
        end

        // random sessions, capacity changed between phases
        stop_at  = items_sent + RANDOM_ITEMS;
        next_cfg = items_sent;
        cfg_step = 0;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_cfg)
            begin
                settle();
                case (cfg_step % 5)
                    0: cap_value = 32'd1;
                    1: cap_value = 32'hFFFFFFFF;
                    2: cap_value = $urandom_range(20, 300);
                    3: cap_value = $urandom;
                    default: cap_value = CAPACITY_RESET;
                endcase
                set_capacity(cap_value);
                cfg_step++;
                next_cfg = items_sent + CFG_SPACING;
            end
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                size = $urandom_range(1, 40);
                run_session(size, byte_count_for(size), 12, 0, 1'b0);
            end
            else if (roll < 86)
            begin
                size = $urandom_range(41, 250);
                run_session(size, byte_count_for(size), 64, 0, 1'b0);
            end
            else if (roll < 94)
                run_session($urandom, $urandom_range(0, 6), 4, 0, 1'b0);
            else
            begin
                repeat ($urandom_range(1, 6)) send_item(random_item(), 1'b0, '0);
            end
        end

        // drain and report
        settle();
        if (fail_count == 0)
            $display("PASS firmware_image_receive_session_unit");
        else
            $display("FAIL firmware_image_receive_session_unit");
        $finish;
    end

endmodule
